[design/pnc_pkg.sv]
// types and constants shared by the palette nearest color block
`timescale 1ns / 1ps
package pnc_pkg;

  localparam int DEFAULT_PALETTE_DEPTH = 16;
  localparam int SIZE_W  = 5;
  localparam int INDEX_W = 4;
  localparam int CHAN_W  = 8;
  localparam int DIST_W  = 10;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [INDEX_W-1:0] entry_index;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_red;
    logic [INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]  best_distance;
  } pix_out_t;

  // one item travelling along the cell chain, with the best match so far
  typedef struct packed {
    logic               valid;
    pix_in_t            item;
    logic [CHAN_W-1:0]  best_blue;
    logic [CHAN_W-1:0]  best_green;
    logic [CHAN_W-1:0]  best_red;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
  } token_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[design/palette_nearest_color_l1.sv]
// top level: nearest palette color by manhattan distance over a chain of cells
`timescale 1ns / 1ps
// Each palette entry lives in its own cell, and the cells form a chain that every
// item walks through, one cell per clock unless the chain holds. The block takes
// one item per clock when the output side is not stalled; out_data comes from the
// last cell's register. Load items walk the same chain and write their entry when
// they reach its cell, so pixels and loads keep stream order; a load produces no
// result. The whole chain holds while a result waits. The user writes palette_size
// via cfg_we and cfg_wdata only while idle; the block does not enforce this. Zero
// counts as one entry and values above PALETTE_DEPTH are clamped to it.
module palette_nearest_color_l1
  import pnc_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pix_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pix_out_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0] palette_size;
  logic [SIZE_W-1:0] use_count;
  logic              advance;
  token_t            chain [0:PALETTE_DEPTH];
  token_t            last;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= SIZE_RESET;
    end else if (cfg_we) begin
      palette_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (palette_size == '0) begin
      use_count = SIZE_W'(1);
    end else if (int'(palette_size) > PALETTE_DEPTH) begin
      use_count = SIZE_W'(PALETTE_DEPTH);
    end else begin
      use_count = palette_size;
    end
  end

  assign last      = chain[PALETTE_DEPTH];
  assign out_valid = last.valid && (last.item.operation == OP_PIXEL);
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  assign chain[0] = '{valid: in_valid, item: in_data, default: '0};

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    pnc_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .use_count (use_count),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1])
    );
  end

  assign out_data.out_blue      = last.best_blue;
  assign out_data.out_green     = last.best_green;
  assign out_data.out_red       = last.best_red;
  assign out_data.nearest_index = last.best_index;
  assign out_data.best_distance = last.best_distance;

endmodule

[design/pnc_cell.sv]
// one cell of the chain: holds a palette entry and updates the passing best match
`timescale 1ns / 1ps
module pnc_cell
  import pnc_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [SIZE_W-1:0] use_count,
  input  token_t            tok_in,
  output token_t            tok_out
);

  logic [CHAN_W-1:0] entry_blue;
  logic [CHAN_W-1:0] entry_green;
  logic [CHAN_W-1:0] entry_red;

  logic [DIST_W-1:0] entry_gap;
  logic              active;
  logic              take;
  logic              load_here;
  token_t            tok_next;

  assign entry_gap = DIST_W'(abs_diff(entry_blue, tok_in.item.blue))
                   + DIST_W'(abs_diff(entry_green, tok_in.item.green))
                   + DIST_W'(abs_diff(entry_red, tok_in.item.red));

  assign active    = CELL_INDEX < int'(use_count);
  // the first cell always replaces whatever best values enter the chain
  assign take      = active && ((CELL_INDEX == 0) || (entry_gap < tok_in.best_distance));
  assign load_here = tok_in.valid && (tok_in.item.operation == OP_LOAD)
                   && (int'(tok_in.item.entry_index) == CELL_INDEX);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.item.operation == OP_PIXEL && take) begin
      tok_next.best_blue     = entry_blue;
      tok_next.best_green    = entry_green;
      tok_next.best_red      = entry_red;
      tok_next.best_index    = INDEX_W'(CELL_INDEX);
      tok_next.best_distance = entry_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

  // the load updates the entry as it passes; pixels behind it see the new color
  always_ff @(posedge clk) begin
    if (advance && load_here) begin
      entry_blue  <= tok_in.item.blue;
      entry_green <= tok_in.item.green;
      entry_red   <= tok_in.item.red;
    end
  end

endmodule

[design/pnc_checker.sv]
// port level checks for the palette nearest color block
`timescale 1ns / 1ps
module pnc_checker
  import pnc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pix_out_t out_data
);

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // input side only holds back while a result is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.best_distance <= DIST_W'(765))
    else $error("distance out of range");

endmodule

bind palette_nearest_color_l1 pnc_checker u_pnc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/palette_nearest_color_l1_tb.sv]
// self-checking testbench for the nearest palette color block
`timescale 1ns / 1ps
module palette_nearest_color_l1_tb;
  import pnc_pkg::*;

  localparam int DEPTH = 16;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_LIMIT = 4000;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } color_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_SIZE
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    pix_in_t           item;
    logic [SIZE_W-1:0] size_val;
    pix_out_t          result;
  } row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pix_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pix_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // shadow of the block: palette contents, which entries hold data, size register
  color_t            palette_model [DEPTH];
  bit [DEPTH-1:0]    written = '0;
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;

  pix_out_t          expected_q [$];
  row_t              directed_rows [$];
  int                mismatch_count = 0;
  bit                no_idle = 1'b0;

  palette_nearest_color_l1 #(
    .PALETTE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int entries_in_use();
    if (size_reg == 0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return int'(size_reg);
  endfunction

  function automatic int chan_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
    int diff;
    diff = int'(a) - int'(b);
    return (diff < 0) ? -diff : diff;
  endfunction

  function automatic pix_out_t nearest_color(input pix_in_t px);
    pix_out_t res;
    int n, i, d, best_d, best_i;
    n = entries_in_use();
    best_d = 1 << DIST_W;
    best_i = 0;
    for (i = 0; i < n; i++) begin
      d = chan_gap(palette_model[i].blue, px.blue) + chan_gap(palette_model[i].green, px.green)
        + chan_gap(palette_model[i].red, px.red);
      // strict compare keeps the lowest index on a tie
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    res.out_blue = palette_model[best_i].blue;
    res.out_green = palette_model[best_i].green;
    res.out_red = palette_model[best_i].red;
    res.nearest_index = INDEX_W'(best_i);
    res.best_distance = DIST_W'(best_d);
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] random_channel();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  function automatic pix_in_t random_item();
    pix_in_t it;
    int n, i, unwritten, sel, pick;
    n = entries_in_use();
    unwritten = -1;
    for (i = n - 1; i >= 0; i--) if (!written[i]) unwritten = i;
    sel = $urandom_range(0, 99);
    it.blue = random_channel();
    it.green = random_channel();
    it.red = random_channel();
    // a search must never reach an entry that holds no data yet
    if (unwritten >= 0) begin
      it.operation = OP_LOAD;
      it.entry_index = INDEX_W'(unwritten);
    end else begin
      it.operation = (sel < 25) ? OP_LOAD : OP_PIXEL;
      it.entry_index = INDEX_W'($urandom_range(0, DEPTH - 1));
      pick = $urandom_range(0, n - 1);
      if (it.operation == OP_LOAD && sel < 8) begin
        // copy a color from inside the searched range, which can create ties
        it.blue = palette_model[pick].blue;
        it.green = palette_model[pick].green;
        it.red = palette_model[pick].red;
      end else if (it.operation == OP_PIXEL && sel >= 90) begin
        it.blue = palette_model[pick].blue;
        it.green = palette_model[pick].green;
        it.red = palette_model[pick].red;
      end else if (it.operation == OP_PIXEL && sel >= 60) begin
        it.blue = nudge(palette_model[pick].blue);
        it.green = nudge(palette_model[pick].green);
        it.red = nudge(palette_model[pick].red);
      end
    end
    return it;
  endfunction

  task automatic transfer_item(input pix_in_t it, input bit typed, input pix_out_t typed_result);
    int gap;
    pix_out_t want;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (it.operation == OP_LOAD) begin
      palette_model[it.entry_index] = '{it.blue, it.green, it.red};
      written[it.entry_index] = 1'b1;
    end else begin
      want = typed ? typed_result : nearest_color(it);
      expected_q = {expected_q, want};
    end
  endtask

  // wait out every expected result, then wait on so that loads settle too
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      expected_q.delete();
    end
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_palette_size(input logic [SIZE_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = value;
  endtask

  function automatic row_t load_row(input int idx, input int b, input int g, input int r);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = '{OP_LOAD, INDEX_W'(idx), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
    return row;
  endfunction

  function automatic row_t pixel_row(input int b, input int g, input int r);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = '{OP_PIXEL, INDEX_W'(0), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
    return row;
  endfunction

  function automatic row_t checked_row(input int b, input int g, input int r, input int ob,
                                       input int og, input int orr, input int oi, input int od);
    row_t row;
    row = pixel_row(b, g, r);
    row.kind = ROW_CHECKED;
    row.result = '{CHAN_W'(ob), CHAN_W'(og), CHAN_W'(orr), INDEX_W'(oi), DIST_W'(od)};
    return row;
  endfunction

  function automatic row_t size_row(input int value);
    row_t row;
    row = '0;
    row.kind = ROW_SIZE;
    row.size_val = SIZE_W'(value);
    return row;
  endfunction

  // receiver: random stall before each result, no stall while no_idle is set
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_result
    pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_blue !== want.out_blue)
          flag_mismatch($sformatf("out_blue %0d, want %0d", out_data.out_blue, want.out_blue));
        if (out_data.out_green !== want.out_green)
          flag_mismatch($sformatf("out_green %0d, want %0d", out_data.out_green,
                                  want.out_green));
        if (out_data.out_red !== want.out_red)
          flag_mismatch($sformatf("out_red %0d, want %0d", out_data.out_red, want.out_red));
        if (out_data.nearest_index !== want.nearest_index)
          flag_mismatch($sformatf("nearest_index %0d, want %0d", out_data.nearest_index,
                                  want.nearest_index));
        if (out_data.best_distance !== want.best_distance)
          flag_mismatch($sformatf("best_distance %0d, want %0d", out_data.best_distance,
                                  want.best_distance));
      end
    end
  end

  initial begin
    int k, p, j;
    logic [SIZE_W-1:0] phase_sizes [PHASES];
    logic [SIZE_W-1:0] next_size;
    phase_sizes = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd5, 5'd2, 5'd24, 5'd16, 5'd9};
    directed_rows = '{
      load_row(0, 0, 0, 0),
      load_row(1, 255, 255, 255),
      // size is one out of reset, so only entry 0 is searched
      checked_row(255, 255, 255, 0, 0, 0, 0, 765),
      checked_row(0, 0, 0, 0, 0, 0, 0, 0),
      size_row(0),
      checked_row(200, 200, 200, 0, 0, 0, 0, 600),
      size_row(2),
      checked_row(200, 200, 200, 255, 255, 255, 1, 165),
      load_row(2, 10, 0, 20),
      load_row(3, 0, 10, 20),
      size_row(4),
      // entries 2 and 3 tie, lower index wins
      checked_row(5, 5, 20, 10, 0, 20, 2, 10),
      checked_row(0, 10, 20, 0, 10, 20, 3, 0),
      pixel_row(128, 64, 32),
      load_row(15, 8'h5a, 8'ha5, 8'hff),
      pixel_row(255, 0, 255),
      load_row(1, 1, 2, 3),
      pixel_row(2, 2, 4),
      pixel_row(127, 128, 129),
      load_row(0, 255, 0, 0),
      pixel_row(0, 0, 0),
      pixel_row(255, 255, 0)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < directed_rows.size(); k++) begin
      case (directed_rows[k].kind)
        ROW_SIZE: set_palette_size(directed_rows[k].size_val);
        ROW_CHECKED: transfer_item(directed_rows[k].item, 1'b1, directed_rows[k].result);
        default: transfer_item(directed_rows[k].item, 1'b0, '0);
      endcase
    end

    for (p = 0; p < PHASES; p++) begin
      next_size = (p == PHASES - 1) ? SIZE_W'($urandom_range(0, 31)) : phase_sizes[p];
      set_palette_size(next_size);
      for (j = 0; j < ITEMS_PER_PHASE; j++) begin
        if (j % 35 == 0) no_idle = ($urandom_range(0, 3) == 0);
        transfer_item(random_item(), 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
